[sv/smoothed_zscore_peak_detector_macros.svh]
// Assertion macros shared by the checker of the peak detector.
`ifndef SMOOTHED_ZSCORE_PEAK_DETECTOR_MACROS_SVH
`define SMOOTHED_ZSCORE_PEAK_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SZPD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SZPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also checks across reset.
`define SZPD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/szpd_pkg.sv]
// Constants, widths and helper functions of the smoothed z-score peak detector.
package szpd_pkg;

   // Storage and sample size
   localparam int WINDOW_DEPTH = 32;
   localparam int SAMPLE_WIDTH = 16;

   // Register widths
   localparam int WL_W       = 6;
   localparam int THR_W      = 4;
   localparam int INF_W      = 9;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 9;

   // Derived datapath widths
   localparam int PTR_W   = $clog2(WINDOW_DEPTH);
   localparam int LEN_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int TT_W    = 2 * THR_W;
   localparam int SUM_W   = SAMPLE_WIDTH + PTR_W;
   localparam int SQ1_W   = 2 * SAMPLE_WIDTH - 1;
   localparam int SQ_W    = SQ1_W + PTR_W;
   localparam int LQ_W    = SQ_W + PTR_W;
   localparam int D_W     = SUM_W + 1;
   localparam int DD_W    = 2 * (D_W - 1);
   localparam int TV_W    = LQ_W + TT_W;
   localparam int NUM_W   = SAMPLE_WIDTH + INF_W + 2;
   localparam int MUL_A_W = LQ_W + 1;
   localparam int MUL_B_W = D_W;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Stream word widths
   localparam int PEAK_W      = 2;
   localparam int REQ_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((PEAK_W + 7) / 8) * 8;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_THRESHOLD     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_INFLUENCE     = 2'd2;

   // Register reset values
   localparam logic [WL_W-1:0]  WL_RESET  = 6'd10;
   localparam logic [THR_W-1:0] THR_RESET = 4'd2;
   localparam logic [INF_W-1:0] INF_RESET = 9'd51;

   // Peak codes
   localparam logic [PEAK_W-1:0] PEAK_NONE = 2'b00;
   localparam logic [PEAK_W-1:0] PEAK_POS  = 2'b01;
   localparam logic [PEAK_W-1:0] PEAK_NEG  = 2'b11;

   // Blend: Q1.8 weight, one equals 256, round half up
   localparam int                FRAC_BITS   = 8;
   localparam logic [INF_W-1:0]  INF_ONE     = INF_W'(256);
   localparam logic [NUM_W-1:0]  BLEND_ROUND = NUM_W'(128);

   // Ring pointer constants
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(WINDOW_DEPTH);

   // Window length as used: zero means one, clipped to the ring depth
   function automatic logic [LEN_W-1:0] eff_len(input logic [WL_W-1:0] wl);
      int l;
      l = int'(wl);
      if (l == 0) l = 1;
      if (l > WINDOW_DEPTH) l = WINDOW_DEPTH;
      return LEN_W'(l);
   endfunction

   // Influence as used: clipped to one
   function automatic logic [INF_W-1:0] eff_inf(input logic [INF_W-1:0] inf);
      return (inf > INF_ONE) ? INF_ONE : inf;
   endfunction

endpackage

[sv/szpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module szpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/szpd_mul.sv]
// Shared signed multiplier with a registered product.
module szpd_mul (
   input  logic                                clock,
   input  logic signed [szpd_pkg::MUL_A_W-1:0] mul_a,
   input  logic signed [szpd_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [szpd_pkg::MUL_P_W-1:0] mul_p
);

   logic signed [szpd_pkg::MUL_P_W-1:0] prod_ff;

   // One product per cycle, registered before any further use
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign mul_p = prod_ff;

endmodule

[sv/smoothed_zscore_peak_detector.sv]
// Smoothed z-score peak detector: top level with sequencer and running window sums.
// Each word taken on req passes the steps LX, LQ, SS, TT, DD, TV, CMP, BL1, BL2, FF and UPD;
// no new word is taken until it is done, as one shared multiplier forms its ten products in turn.
// A stalled rsp word holds the sequencer in its last step until the output register frees.
// A window_length write rebuilds the sums over the last L entries (L the clipped length).
// Reset (synchronous) restores register defaults; the ring reads as zero through valid bits.
module smoothed_zscore_peak_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [szpd_pkg::REQ_TDATA_W-1:0]     req_tdata,   // [15:0] sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [szpd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // [1:0] peak_signal, rest zero
   input  logic                                 csr_we,
   input  logic [szpd_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [szpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LX,
      ST_LQ,
      ST_SS,
      ST_TT,
      ST_DD,
      ST_TV,
      ST_CMP,
      ST_BL1,
      ST_BL2,
      ST_FF,
      ST_UPD,
      ST_RB_START,
      ST_RB_SQ,
      ST_RB_ACC
   } state_type;

   state_type state_ff;

   // Configuration
   logic [szpd_pkg::WL_W-1:0]  wl_ff;
   logic [szpd_pkg::THR_W-1:0] thr_ff;
   logic [szpd_pkg::INF_W-1:0] inf_ff;

   // Window state
   logic [szpd_pkg::PTR_W-1:0]        wp_ff;
   logic signed [szpd_pkg::SUM_W-1:0] s_ff;
   logic [szpd_pkg::SQ_W-1:0]         q_ff;
   logic [szpd_pkg::WINDOW_DEPTH-1:0] valid_ff;

   // Per-word datapath
   logic signed [szpd_pkg::SAMPLE_WIDTH-1:0] x_ff;
   logic signed [szpd_pkg::SAMPLE_WIDTH-1:0] prev_ff;
   logic signed [szpd_pkg::SAMPLE_WIDTH-1:0] old_ff;
   logic signed [szpd_pkg::SAMPLE_WIDTH-1:0] f_ff;
   logic signed [szpd_pkg::D_W-1:0]          d_ff;
   logic [szpd_pkg::LQ_W-1:0]                lq_ff;
   logic [szpd_pkg::LQ_W-1:0]                v_ff;
   logic [szpd_pkg::TT_W-1:0]                tt_ff;
   logic [szpd_pkg::DD_W-1:0]                dd_ff;
   logic                                     outside_ff;
   logic signed [szpd_pkg::NUM_W-1:0]        num_ff;
   logic [szpd_pkg::SQ1_W-1:0]               oo_ff;

   // Rebuild walk
   logic [szpd_pkg::PTR_W-1:0] pos_ff;
   logic [szpd_pkg::LEN_W-1:0] cnt_ff;

   // Ring read side and output register
   logic                         rd_valid_ff;
   logic                         rsp_valid_ff;
   logic [szpd_pkg::PEAK_W-1:0]  rsp_peak_ff;

   // Combinational signals
   logic [szpd_pkg::LEN_W-1:0]                l_eff;
   logic [szpd_pkg::INF_W-1:0]                inf_eff;
   logic [szpd_pkg::PTR_W-1:0]                prev_pos;
   logic [szpd_pkg::PTR_W:0]                  old_sum;
   logic [szpd_pkg::PTR_W-1:0]                old_pos;
   logic [szpd_pkg::PTR_W-1:0]                pos_dec;
   logic [szpd_pkg::PTR_W-1:0]                wp_in;
   logic [szpd_pkg::PTR_W-1:0]                rd_addr;
   logic [szpd_pkg::SAMPLE_WIDTH-1:0]         ram_rd_data;
   logic signed [szpd_pkg::SAMPLE_WIDTH-1:0]  ring_rd;
   logic                                      ram_we;
   logic signed [szpd_pkg::MUL_A_W-1:0]       mul_a;
   logic signed [szpd_pkg::MUL_B_W-1:0]       mul_b;
   logic signed [szpd_pkg::MUL_P_W-1:0]       mul_p;
   logic signed [szpd_pkg::NUM_W-1:0]         blend_sum;
   logic                                      out_free;
   logic                                      wl_write;

   // Effective register values
   assign l_eff   = szpd_pkg::eff_len(wl_ff);
   assign inf_eff = szpd_pkg::eff_inf(inf_ff);

   // Ring positions, modulo the depth
   assign prev_pos = (wp_ff == '0) ? szpd_pkg::PTR_LAST : wp_ff - 1'b1;
   assign old_sum  = {1'b0, wp_ff} + szpd_pkg::DEPTH_X - (szpd_pkg::PTR_W + 1)'(l_eff);
   assign old_pos  = (old_sum >= szpd_pkg::DEPTH_X) ?
                     szpd_pkg::PTR_W'(old_sum - szpd_pkg::DEPTH_X) :
                     old_sum[szpd_pkg::PTR_W-1:0];
   assign pos_dec  = (pos_ff == '0) ? szpd_pkg::PTR_LAST : pos_ff - 1'b1;
   assign wp_in    = (wp_ff == szpd_pkg::PTR_LAST) ? '0 : wp_ff + 1'b1;

   // Handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign wl_write   = csr_we && (csr_addr == szpd_pkg::REG_WINDOW_LENGTH);
   assign req_tready = (state_ff == ST_IDLE) && !wl_write;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = szpd_pkg::RSP_TDATA_W'(rsp_peak_ff);

   // Ring read address per step
   always_comb begin
      case (state_ff)
         ST_IDLE:     rd_addr = prev_pos;
         ST_LX:       rd_addr = old_pos;
         ST_RB_START: rd_addr = prev_pos;
         ST_RB_ACC:   rd_addr = pos_dec;
         default:     rd_addr = prev_pos;
      endcase
   end

   // Entries never written read as zero
   assign ring_rd = rd_valid_ff ? ram_rd_data : '0;
   assign ram_we  = (state_ff == ST_UPD) && out_free;

   // Blend sum; floor by 256 is the bit slice above the fraction
   assign blend_sum = num_ff + $signed(mul_p[szpd_pkg::NUM_W-1:0]);

   // Shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_LX: begin
            mul_a = szpd_pkg::MUL_A_W'(x_ff);
            mul_b = szpd_pkg::MUL_B_W'(l_eff);
         end
         ST_LQ: begin
            mul_a = szpd_pkg::MUL_A_W'(q_ff);
            mul_b = szpd_pkg::MUL_B_W'(l_eff);
         end
         ST_SS: begin
            mul_a = szpd_pkg::MUL_A_W'(s_ff);
            mul_b = szpd_pkg::MUL_B_W'(s_ff);
         end
         ST_TT: begin
            mul_a = szpd_pkg::MUL_A_W'(thr_ff);
            mul_b = szpd_pkg::MUL_B_W'(thr_ff);
         end
         ST_DD: begin
            mul_a = szpd_pkg::MUL_A_W'(d_ff);
            mul_b = szpd_pkg::MUL_B_W'(d_ff);
         end
         ST_TV: begin
            mul_a = szpd_pkg::MUL_A_W'(v_ff);
            mul_b = szpd_pkg::MUL_B_W'(tt_ff);
         end
         ST_CMP: begin
            mul_a = szpd_pkg::MUL_A_W'(x_ff);
            mul_b = szpd_pkg::MUL_B_W'(inf_eff);
         end
         ST_BL1: begin
            mul_a = szpd_pkg::MUL_A_W'(prev_ff);
            mul_b = szpd_pkg::MUL_B_W'(szpd_pkg::INF_ONE - inf_eff);
         end
         ST_BL2: begin
            mul_a = szpd_pkg::MUL_A_W'(old_ff);
            mul_b = szpd_pkg::MUL_B_W'(old_ff);
         end
         ST_FF, ST_UPD: begin
            mul_a = szpd_pkg::MUL_A_W'(f_ff);
            mul_b = szpd_pkg::MUL_B_W'(f_ff);
         end
         ST_RB_SQ: begin
            mul_a = szpd_pkg::MUL_A_W'(ring_rd);
            mul_b = szpd_pkg::MUL_B_W'(ring_rd);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   szpd_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   szpd_ram #(
      .WIDTH (szpd_pkg::SAMPLE_WIDTH),
      .DEPTH (szpd_pkg::WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (f_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer, window state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wl_ff        <= szpd_pkg::WL_RESET;
         thr_ff       <= szpd_pkg::THR_RESET;
         inf_ff       <= szpd_pkg::INF_RESET;
         wp_ff        <= '0;
         s_ff         <= '0;
         q_ff         <= '0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];

         // Register writes
         if (csr_we) begin
            case (csr_addr)
               szpd_pkg::REG_WINDOW_LENGTH: wl_ff  <= csr_wdata[szpd_pkg::WL_W-1:0];
               szpd_pkg::REG_THRESHOLD:     thr_ff <= csr_wdata[szpd_pkg::THR_W-1:0];
               szpd_pkg::REG_INFLUENCE:     inf_ff <= csr_wdata[szpd_pkg::INF_W-1:0];
               default: ;
            endcase
         end

         // Taken word leaves; the update step reloads the register itself
         if (rsp_tready && (state_ff != ST_UPD)) begin
            rsp_valid_ff <= 1'b0;
         end

         // A new window length restarts the rebuild
         if (wl_write) begin
            state_ff <= ST_RB_START;
         end else begin
            case (state_ff)
               ST_IDLE: begin
                  if (req_tvalid && req_tready) begin
                     x_ff     <= req_tdata[szpd_pkg::SAMPLE_WIDTH-1:0];
                     state_ff <= ST_LX;
                  end
               end
               // L * x in flight; previous filtered value arrives
               ST_LX: begin
                  prev_ff  <= ring_rd;
                  state_ff <= ST_LQ;
               end
               // Deviation times L; oldest window entry arrives
               ST_LQ: begin
                  d_ff     <= mul_p[szpd_pkg::D_W-1:0] - szpd_pkg::D_W'(s_ff);
                  old_ff   <= ring_rd;
                  state_ff <= ST_SS;
               end
               ST_SS: begin
                  lq_ff    <= mul_p[szpd_pkg::LQ_W-1:0];
                  state_ff <= ST_TT;
               end
               // L^2 times the variance, never negative
               ST_TT: begin
                  v_ff     <= lq_ff - mul_p[szpd_pkg::LQ_W-1:0];
                  state_ff <= ST_DD;
               end
               ST_DD: begin
                  tt_ff    <= mul_p[szpd_pkg::TT_W-1:0];
                  state_ff <= ST_TV;
               end
               ST_TV: begin
                  dd_ff    <= mul_p[szpd_pkg::DD_W-1:0];
                  state_ff <= ST_CMP;
               end
               // Squared deviation against squared band
               ST_CMP: begin
                  outside_ff <= (d_ff != '0) &&
                                (szpd_pkg::TV_W'(dd_ff) > mul_p[szpd_pkg::TV_W-1:0]);
                  state_ff   <= ST_BL1;
               end
               ST_BL1: begin
                  num_ff   <= mul_p[szpd_pkg::NUM_W-1:0] + szpd_pkg::BLEND_ROUND;
                  state_ff <= ST_BL2;
               end
               // Peak stores the blend, anything else the raw sample
               ST_BL2: begin
                  f_ff     <= outside_ff ?
                              blend_sum[szpd_pkg::FRAC_BITS +: szpd_pkg::SAMPLE_WIDTH] : x_ff;
                  state_ff <= ST_FF;
               end
               ST_FF: begin
                  oo_ff    <= mul_p[szpd_pkg::SQ1_W-1:0];
                  state_ff <= ST_UPD;
               end
               // Slide the window and post the result once the output register is free
               ST_UPD: begin
                  if (out_free) begin
                     s_ff            <= s_ff + szpd_pkg::SUM_W'(f_ff)
                                        - szpd_pkg::SUM_W'(old_ff);
                     q_ff            <= q_ff + szpd_pkg::SQ_W'(mul_p[szpd_pkg::SQ1_W-1:0])
                                        - szpd_pkg::SQ_W'(oo_ff);
                     valid_ff[wp_ff] <= 1'b1;
                     wp_ff           <= wp_in;
                     rsp_valid_ff    <= 1'b1;
                     rsp_peak_ff     <= !outside_ff ? szpd_pkg::PEAK_NONE :
                                        (d_ff[szpd_pkg::D_W-1] ? szpd_pkg::PEAK_NEG :
                                                                 szpd_pkg::PEAK_POS);
                     state_ff        <= ST_IDLE;
                  end
               end
               // Rebuild: walk back from the newest entry over the window
               ST_RB_START: begin
                  s_ff     <= '0;
                  q_ff     <= '0;
                  cnt_ff   <= l_eff;
                  pos_ff   <= prev_pos;
                  state_ff <= ST_RB_SQ;
               end
               ST_RB_SQ: begin
                  s_ff     <= s_ff + szpd_pkg::SUM_W'(ring_rd);
                  state_ff <= ST_RB_ACC;
               end
               ST_RB_ACC: begin
                  q_ff <= q_ff + szpd_pkg::SQ_W'(mul_p[szpd_pkg::SQ1_W-1:0]);
                  if (cnt_ff == szpd_pkg::LEN_W'(1)) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     cnt_ff   <= cnt_ff - 1'b1;
                     pos_ff   <= pos_dec;
                     state_ff <= ST_RB_SQ;
                  end
               end
               default: begin
                  state_ff <= ST_IDLE;
               end
            endcase
         end
      end
   end

endmodule

[sv/szpd_chk.sv]
// Port-level checker of the peak detector and its bind to the top level.
`include "smoothed_zscore_peak_detector_macros.svh"

module szpd_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [szpd_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [szpd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             csr_we,
   input logic [szpd_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input logic [szpd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // A stalled result word holds
   `SZPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")

   // One word at a time: busy right after a request is taken
   `SZPD_ASSERT_NEXT(a_req_busy, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while a word is in work")

   // A window length write starts the rebuild
   `SZPD_ASSERT_NEXT(a_rebuild_busy, clock, reset, csr_we && csr_addr == szpd_pkg::REG_WINDOW_LENGTH, !req_tready, "request side open during rebuild")

   // A result only appears out of a busy sequencer
   `SZPD_ASSERT_SAME(a_rsp_from_work, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result appeared while idle")

   // Reset empties the output register
   `SZPD_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "result valid after reset")

endmodule

bind smoothed_zscore_peak_detector szpd_chk u_szpd_chk (.*);
